/* sv/rfc_pkg.sv */
// Package for the rail fence cipher unit: sizes, microcode word layout and
// the microcode program itself. No dependencies.

package rfc_pkg;

   localparam int MAX_LEN   = 64;
   localparam int ADDR_W    = $clog2(MAX_LEN);
   localparam int CNT_W     = ADDR_W + 1;
   localparam int RAIL_W    = 6;
   localparam int KEY_W     = 7;
   localparam int MAX_RAILS = 64;
   localparam int UPC_W     = 4;

   typedef enum logic [3:0] {
      ACT_NONE,
      ACT_LOAD,
      ACT_INIT,
      ACT_DEC_WR,
      ACT_EMIT_BUF,
      ACT_ADVANCE,
      ACT_CLR_P,
      ACT_EMIT_RES,
      ACT_P_INC
   } act_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NOT_LAST_ACC,
      COND_TAG_MISS,
      COND_IS_DEC,
      COND_IS_ENC,
      COND_OUT_BUSY,
      COND_SCAN_MORE,
      COND_P_MORE
   } cond_type;

   typedef struct packed {
      act_type          act;
      cond_type         cond;
      logic [UPC_W-1:0] target;
   } ctrl_word_type;

   // Step addresses of the program.
   localparam logic [UPC_W-1:0] STEP_IDLE     = 4'd0;
   localparam logic [UPC_W-1:0] STEP_INIT     = 4'd1;
   localparam logic [UPC_W-1:0] STEP_READ     = 4'd2;
   localparam logic [UPC_W-1:0] STEP_TEST     = 4'd3;
   localparam logic [UPC_W-1:0] STEP_DEC_WR   = 4'd4;
   localparam logic [UPC_W-1:0] STEP_ENC_EMIT = 4'd5;
   localparam logic [UPC_W-1:0] STEP_ADVANCE  = 4'd6;
   localparam logic [UPC_W-1:0] STEP_MODE     = 4'd7;
   localparam logic [UPC_W-1:0] STEP_CLR_P    = 4'd8;
   localparam logic [UPC_W-1:0] STEP_RES_RD   = 4'd9;
   localparam logic [UPC_W-1:0] STEP_RES_EMIT = 4'd10;
   localparam logic [UPC_W-1:0] STEP_P_INC    = 4'd11;
   localparam logic [UPC_W-1:0] STEP_RETURN   = 4'd12;

   // Microcode store. A taken condition jumps to target, else the step
   // counter moves on by one.
   function automatic ctrl_word_type ucode_rom(input logic [UPC_W-1:0] upc);
      ctrl_word_type w;
      w = '{act: ACT_NONE, cond: COND_ALWAYS, target: STEP_IDLE};
      unique case (upc)
         STEP_IDLE:     w = '{ACT_LOAD,     COND_NOT_LAST_ACC, STEP_IDLE};
         STEP_INIT:     w = '{ACT_INIT,     COND_NEVER,        STEP_IDLE};
         STEP_READ:     w = '{ACT_NONE,     COND_NEVER,        STEP_IDLE};
         STEP_TEST:     w = '{ACT_NONE,     COND_TAG_MISS,     STEP_ADVANCE};
         STEP_DEC_WR:   w = '{ACT_DEC_WR,   COND_IS_DEC,       STEP_ADVANCE};
         STEP_ENC_EMIT: w = '{ACT_EMIT_BUF, COND_OUT_BUSY,     STEP_ENC_EMIT};
         STEP_ADVANCE:  w = '{ACT_ADVANCE,  COND_SCAN_MORE,    STEP_READ};
         STEP_MODE:     w = '{ACT_NONE,     COND_IS_ENC,       STEP_IDLE};
         STEP_CLR_P:    w = '{ACT_CLR_P,    COND_NEVER,        STEP_IDLE};
         STEP_RES_RD:   w = '{ACT_NONE,     COND_NEVER,        STEP_IDLE};
         STEP_RES_EMIT: w = '{ACT_EMIT_RES, COND_OUT_BUSY,     STEP_RES_EMIT};
         STEP_P_INC:    w = '{ACT_P_INC,    COND_P_MORE,       STEP_RES_RD};
         STEP_RETURN:   w = '{ACT_NONE,     COND_ALWAYS,       STEP_IDLE};
         default:       w = '{ACT_NONE,     COND_ALWAYS,       STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

/* sv/rail_fence_cipher_unit.sv */
// Rail fence cipher unit: a microcoded sequencer over a message buffer, a
// rail tag store and a decrypt result store. Depends on rfc_pkg.
//
// Loading takes one word per cycle; the word flagged last starts emission.
// Emission scans (highest rail used + 1) x n buffer slots rail by rail, reading,
// testing and advancing per slot; a matching slot is emitted for encrypt or
// written to the result store for decrypt, and decrypt then reads that store
// out in a second pass. An emit step holds while the output register still
// holds a word. Reset is synchronous, clears the sequencer and counters and
// sets the key to 3 rails; the buffer memories are not cleared.

module rail_fence_cipher_unit
   import rfc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [7:0]       req_tdata,   // [7:0] data_byte
   input  logic             req_tlast,
   input  logic             req_tuser,   // [0] operation
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata,   // [7:0] out_byte
   output logic             rsp_tlast,
   output logic             rsp_tuser,   // [0] truncated
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [KEY_W-1:0] csr_data
);

   // Storage.
   logic [7:0]        buf_mem [MAX_LEN];
   logic [RAIL_W-1:0] tag_mem [MAX_LEN];
   logic [7:0]        res_mem [MAX_LEN];

   logic [7:0]        buf_rd_ff;
   logic [RAIL_W-1:0] tag_rd_ff;
   logic [7:0]        res_rd_ff;

   // Sequencer and datapath registers.
   logic [UPC_W-1:0]  upc_ff, upc_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [RAIL_W-1:0] cur_ff, cur_in;
   logic              down_ff, down_in;
   logic              ovf_ff, ovf_in;
   logic [RAIL_W-1:0] maxr_ff, maxr_in;
   logic              op_ff, op_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic [RAIL_W-1:0] scan_maxr_ff, scan_maxr_in;
   logic              trunc_ff, trunc_in;
   logic [ADDR_W-1:0] p_ff, p_in;
   logic [RAIL_W-1:0] r_ff, r_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic [ADDR_W-1:0] e_ff, e_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic              out_trunc_ff, out_trunc_in;

   ctrl_word_type     cw;
   logic              in_acc;
   logic              out_free;
   logic              full;
   logic [KEY_W-1:0]  rails;
   logic              down_t;
   logic [RAIL_W-1:0] tag_w;
   logic              load_wr;
   logic              p_last;
   logic              e_last;
   logic              cond_ok;
   logic              emit;
   logic [7:0]        emit_byte;
   logic              res_wr;
   logic [ADDR_W-1:0] buf_addr;

   assign cw         = ucode_rom(upc_ff);
   assign req_tready = (cw.act == ACT_LOAD);
   assign in_acc     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !out_valid_ff || rsp_tready;
   assign full       = (count_ff == CNT_W'(MAX_LEN));
   assign p_last     = ({1'b0, p_ff} == n_ff - CNT_W'(1));
   assign e_last     = ({1'b0, e_ff} == n_ff - CNT_W'(1));
   assign buf_addr   = op_ff ? k_ff : p_ff;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_trunc_ff;

   // Effective key: zero acts as one rail, anything above the maximum clamps.
   always_comb begin
      priority if (key_ff == '0) begin
         rails = KEY_W'(1);
      end else if (key_ff > KEY_W'(MAX_RAILS)) begin
         rails = KEY_W'(MAX_RAILS);
      end else begin
         rails = key_ff;
      end
   end

   // Zigzag turn for the incoming byte.
   always_comb begin
      down_t = down_ff;
      if (cur_ff == '0) begin
         down_t = 1'b1;
      end
      if ({1'b0, cur_ff} >= rails - KEY_W'(1)) begin
         down_t = 1'b0;
      end
      tag_w = (rails == KEY_W'(1)) ? '0 : cur_ff;
   end

   always_comb begin
      unique case (cw.cond)
         COND_NEVER:        cond_ok = 1'b0;
         COND_ALWAYS:       cond_ok = 1'b1;
         COND_NOT_LAST_ACC: cond_ok = !(in_acc && req_tlast);
         COND_TAG_MISS:     cond_ok = (tag_rd_ff != r_ff);
         COND_IS_DEC:       cond_ok = op_ff;
         COND_IS_ENC:       cond_ok = !op_ff;
         COND_OUT_BUSY:     cond_ok = !out_free;
         COND_SCAN_MORE:    cond_ok = !(p_last && (r_ff == scan_maxr_ff));
         COND_P_MORE:       cond_ok = !p_last;
         default:           cond_ok = 1'b0;
      endcase
      upc_in = cond_ok ? cw.target : upc_ff + UPC_W'(1);
   end

   always_comb begin
      key_in       = key_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      down_in      = down_ff;
      ovf_in       = ovf_ff;
      maxr_in      = maxr_ff;
      op_in        = op_ff;
      n_in         = n_ff;
      scan_maxr_in = scan_maxr_ff;
      trunc_in     = trunc_ff;
      p_in         = p_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      e_in         = e_ff;
      load_wr      = 1'b0;
      res_wr       = 1'b0;
      emit         = 1'b0;
      emit_byte    = buf_rd_ff;

      if (csr_valid && csr_ready) begin
         key_in = csr_data;
      end

      unique case (cw.act)
         ACT_LOAD: begin
            if (in_acc) begin
               if (req_tlast) begin
                  op_in = req_tuser;
               end
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  load_wr  = 1'b1;
                  count_in = count_ff + CNT_W'(1);
                  if (tag_w > maxr_ff) begin
                     maxr_in = tag_w;
                  end
                  if (rails == KEY_W'(1)) begin
                     cur_in  = '0;
                     down_in = 1'b1;
                  end else begin
                     down_in = down_t;
                     if (down_t) begin
                        cur_in = cur_ff + RAIL_W'(1);
                     end else if (cur_ff != '0) begin
                        cur_in = cur_ff - RAIL_W'(1);
                     end
                  end
               end
            end
         end
         ACT_INIT: begin
            n_in         = count_ff;
            scan_maxr_in = maxr_ff;
            trunc_in     = ovf_ff;
            count_in     = '0;
            cur_in       = '0;
            down_in      = 1'b1;
            ovf_in       = 1'b0;
            maxr_in      = '0;
            p_in         = '0;
            r_in         = '0;
            k_in         = '0;
            e_in         = '0;
         end
         ACT_DEC_WR: begin
            if (op_ff) begin
               res_wr = 1'b1;
               k_in   = k_ff + ADDR_W'(1);
            end
         end
         ACT_EMIT_BUF: begin
            emit = out_free;
         end
         ACT_ADVANCE: begin
            if (p_last) begin
               p_in = '0;
               r_in = r_ff + RAIL_W'(1);
            end else begin
               p_in = p_ff + ADDR_W'(1);
            end
         end
         ACT_CLR_P: begin
            p_in = '0;
         end
         ACT_EMIT_RES: begin
            emit      = out_free;
            emit_byte = res_rd_ff;
         end
         ACT_P_INC: begin
            p_in = p_ff + ADDR_W'(1);
         end
         ACT_NONE: begin
         end
         default: begin
         end
      endcase

      if (emit) begin
         e_in = e_ff + ADDR_W'(1);
      end
   end

   // Output register: holds one result word until the consumer takes it.
   always_comb begin
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      out_trunc_in = out_trunc_ff;
      if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_last_in  = e_last;
         out_trunc_in = trunc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= STEP_IDLE;
         key_ff       <= KEY_W'(3);
         count_ff     <= '0;
         cur_ff       <= '0;
         down_ff      <= 1'b1;
         ovf_ff       <= 1'b0;
         maxr_ff      <= '0;
         op_ff        <= 1'b0;
         n_ff         <= '0;
         scan_maxr_ff <= '0;
         trunc_ff     <= 1'b0;
         p_ff         <= '0;
         r_ff         <= '0;
         k_ff         <= '0;
         e_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         key_ff       <= key_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         down_ff      <= down_in;
         ovf_ff       <= ovf_in;
         maxr_ff      <= maxr_in;
         op_ff        <= op_in;
         n_ff         <= n_in;
         scan_maxr_ff <= scan_maxr_in;
         trunc_ff     <= trunc_in;
         p_ff         <= p_in;
         r_ff         <= r_in;
         k_ff         <= k_in;
         e_ff         <= e_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
      out_trunc_ff <= out_trunc_in;
   end

   // Memories with registered reads; addresses stay put across the steps
   // that consume the read data.
   always_ff @(posedge clock) begin
      if (load_wr) begin
         buf_mem[count_ff[ADDR_W-1:0]] <= req_tdata;
         tag_mem[count_ff[ADDR_W-1:0]] <= tag_w;
      end
      buf_rd_ff <= buf_mem[buf_addr];
      tag_rd_ff <= tag_mem[p_ff];
   end

   always_ff @(posedge clock) begin
      if (res_wr) begin
         res_mem[p_ff] <= buf_rd_ff;
      end
      res_rd_ff <= res_mem[p_ff];
   end

endmodule

/* bench/tb_rail_fence_cipher_unit.sv */
// Testbench for rail_fence_cipher_unit: directed and random messages under several keys,
// with results checked word by word against a zigzag predictor kept in the bench.
// Depends on rfc_pkg and the unit itself.

module tb_rail_fence_cipher_unit;
   import rfc_pkg::*;

   localparam logic        OP_ENCRYPT      = 1'b0;
   localparam logic        OP_DECRYPT      = 1'b1;
   localparam int unsigned RANDOM_ITEMS    = 85;
   localparam int unsigned SETTLE_CYCLES   = 16;
   localparam int unsigned WATCHDOG_LIMIT  = 40000;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       truncated;
   } cipher_word_type;

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [7:0]       req_tdata  = 8'h00;   // [7:0] data_byte
   logic             req_tlast  = 1'b0;
   logic             req_tuser  = 1'b0;    // [0] operation
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;            // [7:0] out_byte
   logic             rsp_tlast;
   logic             rsp_tuser;            // [0] truncated
   logic             csr_valid  = 1'b0;
   logic             csr_ready;
   logic [KEY_W-1:0] csr_data   = '0;

   // Predictor state: the message as loaded so far and the zigzag position.
   logic [7:0]        msg_bytes [MAX_LEN];
   logic [RAIL_W-1:0] msg_rails [MAX_LEN];
   int unsigned       msg_len   = 0;
   logic [RAIL_W-1:0] zig_rail  = '0;
   logic              zig_down  = 1'b1;
   logic              dropped   = 1'b0;
   logic [KEY_W-1:0]  rail_key  = 7'd3;

   cipher_word_type expected_words [$];
   int unsigned  errors     = 0;
   int unsigned  burst_left = 0;
   int unsigned  quiet_cycles;

   rail_fence_cipher_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Loads one word into the predicted buffer; the word flagged last produces
   // the whole transformed message.
   function automatic void absorb_word(input logic op, input logic [7:0] data,
                                       input logic last);
      int unsigned rails;
      int unsigned k;
      int unsigned order [MAX_LEN];
      logic [7:0]  result [MAX_LEN];
      cipher_word_type w;
      if (msg_len < MAX_LEN) begin
         rails = (rail_key == 0) ? 1 : ((rail_key > MAX_RAILS) ? MAX_RAILS : rail_key);
         if (rails == 1) begin
            zig_rail = '0;
            zig_down = 1'b1;
         end else begin
            if (zig_rail == 0) zig_down = 1'b1;
            if (zig_rail >= rails - 1) zig_down = 1'b0;
         end
         msg_bytes[msg_len] = data;
         msg_rails[msg_len] = zig_rail;
         if (rails > 1) begin
            if (zig_down) zig_rail = zig_rail + 1'b1;
            else if (zig_rail > 0) zig_rail = zig_rail - 1'b1;
         end
         msg_len++;
      end else begin
         dropped = 1'b1;
      end
      if (!last) return;
      k = 0;
      for (int unsigned r = 0; r < MAX_RAILS; r++)
         for (int unsigned p = 0; p < msg_len; p++)
            if (msg_rails[p] == r) begin
               order[k] = p;
               k++;
            end
      for (int unsigned i = 0; i < msg_len; i++) begin
         if (op == OP_ENCRYPT) result[i] = msg_bytes[order[i]];
         else result[order[i]] = msg_bytes[i];
      end
      for (int unsigned i = 0; i < msg_len; i++) begin
         w.data      = result[i];
         w.last      = (i + 1 == msg_len);
         w.truncated = dropped;
         expected_words = {expected_words, w};
      end
      msg_len  = 0;
      zig_rail = '0;
      zig_down = 1'b1;
      dropped  = 1'b0;
   endfunction

   always @(posedge clock) begin : monitor
      cipher_word_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) rail_key = csr_data;
         if (req_tvalid && req_tready) absorb_word(req_tuser, req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_words.size() == 0) begin
               $error("unexpected output word: out_byte %h out_last %b truncated %b",
                      rsp_tdata, rsp_tlast, rsp_tuser);
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_tdata !== want.data) begin
                  $error("out_byte: expected %h, got %h", want.data, rsp_tdata);
                  errors++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("out_last: expected %b, got %b", want.last, rsp_tlast);
                  errors++;
               end
               if (rsp_tuser !== want.truncated) begin
                  $error("truncated: expected %b, got %b", want.truncated, rsp_tuser);
                  errors++;
               end
            end
         end
      end
   end

   // The receiver switches between always ready, two random rates and a hard stall.
   initial begin : rsp_stall
      int unsigned mode;
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(10, 100)) begin
            @(posedge clock);
            unique case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               2: rsp_tready <= ($urandom_range(0, 5) != 0);
               default: rsp_tready <= 1'b0;
            endcase
         end
      end
   end

   initial begin : watchdog
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb: failure");
      $finish;
   end

   // Valid stays high after the handshake so that the next word can follow
   // back to back; anything that lets time pass must lower it first.
   task automatic send_word(input logic op, input logic [7:0] data, input logic last);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= op;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   // Sends count random words; only the final one carries op, and it closes
   // the message when closes is set.
   task automatic send_run(input int unsigned count, input logic op, input logic closes);
      for (int unsigned i = 0; i < count; i++)
         send_word((i + 1 == count) ? op : ($urandom_range(0, 1) == 1), 8'($urandom),
                   closes && (i + 1 == count));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_key(input logic [KEY_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      unique case ($urandom_range(0, 7))
         0: return 7'd1;
         1: return 7'd2;
         2: return 7'd0;
         3: return 7'd64;
         4: return 7'd127;
         7: return 7'($urandom_range(0, 127));
         default: return 7'($urandom_range(2, 9));
      endcase
   endfunction

   task automatic test_reset_key();
      send_word(OP_DECRYPT, 8'h00, 1'b0);
      send_word(OP_ENCRYPT, 8'hFF, 1'b0);
      send_run(3, OP_ENCRYPT, 1'b1);
      wait_idle();
   endtask

   task automatic test_single_word_message();
      send_word(OP_DECRYPT, 8'hA5, 1'b1);
      wait_idle();
   endtask

   task automatic test_one_rail();
      write_key(7'd1);
      send_run(4, OP_DECRYPT, 1'b1);
      wait_idle();
   endtask

   task automatic test_zero_rails();
      write_key(7'd0);
      send_run(3, OP_ENCRYPT, 1'b1);
      wait_idle();
   endtask

   task automatic test_rails_above_limit();
      write_key(7'd127);
      send_run(4, OP_DECRYPT, 1'b1);
      wait_idle();
   endtask

   // With eight rails the zigzag reaches rail 5; the new key of three rails
   // must then send it back up from there.
   task automatic test_key_change_mid_message();
      write_key(7'd8);
      send_run(5, OP_ENCRYPT, 1'b0);
      wait_idle();
      write_key(7'd3);
      send_run(3, OP_DECRYPT, 1'b1);
      wait_idle();
   endtask

   task automatic test_random_messages();
      int unsigned sent;
      int unsigned len;
      int unsigned split;
      // A full buffer with one rail per stored word, followed by dropped words.
      write_key(7'd64);
      len = $urandom_range(65, 68);
      send_run(len, ($urandom_range(0, 1) == 1), 1'b1);
      sent = len;
      while (sent < RANDOM_ITEMS) begin
         wait_idle();
         write_key(pick_key());
         repeat ($urandom_range(1, 4)) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 12);
            if (len > 1 && $urandom_range(0, 3) == 0) begin
               split = $urandom_range(1, len - 1);
               send_run(split, OP_ENCRYPT, 1'b0);
               wait_idle();
               write_key(pick_key());
               send_run(len - split, ($urandom_range(0, 1) == 1), 1'b1);
            end else begin
               send_run(len, ($urandom_range(0, 1) == 1), 1'b1);
            end
            sent += len;
         end
      end
      wait_idle();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_key();
      test_single_word_message();
      test_one_rail();
      test_zero_rails();
      test_rails_above_limit();
      test_key_change_mid_message();
      test_random_messages();
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
